// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fpaf_pkg.sv =====
`default_nettype none

package fpaf_pkg;

    localparam int VALUE_W    = 19;
    localparam int FUNC_W     = 2;
    localparam int CHAR_W     = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;
    localparam int MAG_W      = 17;
    localparam int NUM_DIGITS = 5;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 3;
    localparam int BODY_LEN   = 8;
    localparam int PROD_W     = 25;
    localparam int BIN_SHIFT  = 8;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_DIGITS - 1);
    localparam logic [IDX_W-1:0] MAX_IDX  = 3'd6;

    localparam logic [FUNC_W-1:0] FUNC_HUND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_THOU  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_BIN   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    localparam logic [VALUE_W-1:0] LIM_HUND  = 19'd99999;
    localparam logic [VALUE_W-1:0] LIM_THOU  = 19'd9999;
    localparam logic [VALUE_W-1:0] LIM_BIN   = 19'd256000;
    localparam logic [PROD_W-1:0]  BIN_SCALE = 25'd100;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;

    typedef enum logic [1:0] {
        FMT_HUND,
        FMT_THOU,
        FMT_OVF_HUND,
        FMT_OVF_THOU
    } fmt_t;

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    typedef struct packed {
        fmt_t    fmt;
        logic    neg;
        digits_t digits;
    } entry_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        return CH_ZERO + {3'd0, d};
    endfunction

endpackage

`default_nettype wire

// ===== src/fixed_point_ascii_formatter_unit.sv =====
// Fixed-point to ASCII formatter.
// Input stream (s_*): one request per value; s_tdata[18:0] is the signed value,
// s_tuser[1:0] the format (0 hundredths, 1 thousandths, 2 unsigned 1/256,
// 3 same as 0). Output stream (m_*): one ASCII character per transfer in
// m_tdata[6:0], m_tlast on the final character of each value's text.
// A front stage classifies the request and extracts five decimal digits, one
// per cycle, and pushes the result into a small queue; a back stage emits the
// text from the queue head into an output register.
// The first character passes through the front's digit registers, a queue
// slot and the output register. The front accepts a new request as it pushes
// its finished value; throughput is set by the digit extraction loop or the
// one-character output channel, whichever is slower; text length is 4 to 7.
// Reset clears the front, queue and output register; no request is held.
// When m_tready is low the output register holds; the queue then fills and the
// front stalls, with s_tready low while it has a finished value it cannot push.
`default_nettype none

module fixed_point_ascii_formatter_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpaf_pkg::S_TDATA_W-1:0]    s_tdata,   // value[18:0], zero fill
    input  logic [fpaf_pkg::FUNC_W-1:0]       s_tuser,   // func[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpaf_pkg::M_TDATA_W-1:0]    m_tdata,   // char_code[6:0], zero fill
    output logic                              m_tlast
);
    import fpaf_pkg::*;

    logic        push_valid, push_ready;
    entry_t      push_entry;
    logic        q_valid, q_ready;
    entry_t      q_entry;
    logic [CHAR_W-1:0] char_code;

    fpaf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .value      ($signed(s_tdata[VALUE_W-1:0])),
        .func       (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    fpaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_entry  (push_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    fpaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .char_code (char_code),
        .last_char (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - CHAR_W){1'b0}}, char_code};

endmodule

`default_nettype wire

// ===== src/fpaf_front.sv =====
`default_nettype none
`include "assert_macros.svh"

module fpaf_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [fpaf_pkg::VALUE_W-1:0] value,
    input  logic [fpaf_pkg::FUNC_W-1:0]         func,
    output logic                                push_valid,
    input  logic                                push_ready,
    output fpaf_pkg::entry_t                    push_entry
);
    import fpaf_pkg::*;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    fmt_t             fmt_reg, fmt_next;
    logic             neg_reg, neg_next;
    digits_t          digits_reg, digits_next;

    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] abs_val;
    logic               is_neg;
    logic [PROD_W-1:0]  prod;
    logic [MAG_W-1:0]   scaled;
    logic               ovf;
    fmt_t               cls_fmt;
    logic               cls_neg;
    logic [MAG_W-1:0]   cls_mag;
    logic [3:0]         dig;
    logic [MAG_W-1:0]   sub;

    // weight of digit d at the place worked on in step pos (most significant first)
    function automatic logic [MAG_W-1:0] digit_weight(input logic [CNT_W-1:0] pos,
                                                       input int d);
        logic [MAG_W-1:0] w;
        case (pos)
            3'd0:    w = MAG_W'(d * 10000);
            3'd1:    w = MAG_W'(d * 1000);
            3'd2:    w = MAG_W'(d * 100);
            3'd3:    w = MAG_W'(d * 10);
            default: w = MAG_W'(d);
        endcase
        return w;
    endfunction

    // classify the request
    always_comb
    begin
        raw     = value;
        is_neg  = raw[VALUE_W-1];
        abs_val = is_neg ? (~raw + 19'd1) : raw;
        prod    = {7'd0, raw[VALUE_W-2:0]} * BIN_SCALE;
        scaled  = prod[PROD_W-1:BIN_SHIFT];
        unique case (func) inside
            FUNC_THOU:
            begin
                ovf     = abs_val > LIM_THOU;
                cls_fmt = ovf ? FMT_OVF_THOU : FMT_THOU;
                cls_neg = is_neg && !ovf;
                cls_mag = abs_val[MAG_W-1:0];
            end
            FUNC_BIN:
            begin
                ovf     = is_neg || (raw >= LIM_BIN);
                cls_fmt = ovf ? FMT_OVF_HUND : FMT_HUND;
                cls_neg = 1'b0;
                cls_mag = scaled;
            end
            FUNC_HUND, FUNC_SPARE:
            begin
                ovf     = abs_val > LIM_HUND;
                cls_fmt = ovf ? FMT_OVF_HUND : FMT_HUND;
                cls_neg = is_neg && !ovf;
                cls_mag = abs_val[MAG_W-1:0];
            end
        endcase
    end

    // one decimal digit per cycle
    always_comb
    begin
        dig = 4'd0;
        sub = '0;
        for (int d = 1; d <= 9; d++)
        begin
            if (rem_reg >= digit_weight(cnt_reg, d))
            begin
                dig = 4'(d);
                sub = digit_weight(cnt_reg, d);
            end
        end
    end

    always_comb
    begin
        push_valid        = busy_reg && (cnt_reg == LAST_CNT);
        in_ready          = !busy_reg || (push_valid && push_ready);
        push_entry.fmt    = fmt_reg;
        push_entry.neg    = neg_reg;
        push_entry.digits = {digits_reg[NUM_DIGITS-2:0], dig};

        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        fmt_next    = fmt_reg;
        neg_next    = neg_reg;
        digits_next = digits_reg;

        if (busy_reg && (cnt_reg != LAST_CNT))
        begin
            rem_next    = rem_reg - sub;
            digits_next = {digits_reg[NUM_DIGITS-2:0], dig};
            cnt_next    = cnt_reg + 1'b1;
        end
        else if (push_valid && push_ready)
        begin
            busy_next = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = cls_mag;
            fmt_next  = cls_fmt;
            neg_next  = cls_neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        fmt_reg    <= fmt_next;
        neg_reg    <= neg_next;
        digits_reg <= digits_next;
    end

    `ASSERT_IMPLIES(FRONT_CNT_RANGE, busy_reg, cnt_reg <= LAST_CNT, "digit step out of range")

endmodule

`default_nettype wire

// ===== src/fpaf_queue.sv =====
`default_nettype none
`include "assert_macros.svh"

module fpaf_queue #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  fpaf_pkg::entry_t in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output fpaf_pkg::entry_t out_entry
);
    import fpaf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    always_comb
    begin
        in_ready  = count_reg != CNT_W'(DEPTH);
        out_valid = count_reg != '0;
        out_entry = slots_reg[rd_ptr_reg];
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= in_entry;
        end
    end

    `ASSERT_ALWAYS(Q_COUNT_RANGE, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `ASSERT_NEXT(Q_PUSH_GROWS, push && !pop, count_reg == $past(count_reg) + 1'b1, "count lost a push")

endmodule

`default_nettype wire

// ===== src/fpaf_back.sv =====
`default_nettype none
`include "assert_macros.svh"

module fpaf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  fpaf_pkg::entry_t             q_entry,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fpaf_pkg::CHAR_W-1:0]  char_code,
    output logic                         last_char
);
    import fpaf_pkg::*;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic [BODY_LEN-1:0][CHAR_W-1:0] body;
    logic [IDX_W-1:0]  base_len;
    logic [IDX_W-1:0]  skip;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  text_len;
    logic [CHAR_W-1:0] cur_char;
    logic              cur_last;
    logic              advance;
    digits_t           d;

    // text of the head entry, minus sign aside
    always_comb
    begin
        d    = q_entry.digits;
        body = {BODY_LEN{CH_STAR}};
        skip = '0;
        unique case (q_entry.fmt)
            FMT_HUND:
            begin
                body[0]  = digit_char(d[4]);
                body[1]  = digit_char(d[3]);
                body[2]  = digit_char(d[2]);
                body[3]  = CH_DOT;
                body[4]  = digit_char(d[1]);
                body[5]  = digit_char(d[0]);
                base_len = 3'd6;
                if (d[4] == 4'd0)
                begin
                    skip = (d[3] == 4'd0) ? 3'd2 : 3'd1;
                end
            end
            FMT_THOU:
            begin
                body[0]  = digit_char(d[3]);
                body[1]  = CH_DOT;
                body[2]  = digit_char(d[2]);
                body[3]  = digit_char(d[1]);
                body[4]  = digit_char(d[0]);
                base_len = 3'd5;
            end
            FMT_OVF_HUND:
            begin
                body[3]  = CH_DOT;
                base_len = 3'd6;
            end
            FMT_OVF_THOU:
            begin
                body[1]  = CH_DOT;
                base_len = 3'd5;
            end
        endcase

        pos      = idx_reg - {2'd0, q_entry.neg} + skip;
        text_len = base_len + {2'd0, q_entry.neg} - skip;
        cur_char = (q_entry.neg && (idx_reg == '0)) ? CH_MINUS : body[pos];
        cur_last = idx_reg == (text_len - 1'b1);
    end

    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        q_ready        = advance && cur_last;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        if (advance)
        begin
            out_valid_next = q_valid;
            if (q_valid)
            begin
                char_next = cur_char;
                last_next = cur_last;
                idx_next  = cur_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    `ASSERT_ALWAYS(BACK_IDX_RANGE, idx_reg <= MAX_IDX, "character index past longest text")

endmodule

`default_nettype wire
